### sv/grtb_pkg.sv
`timescale 1ns / 1ps
package grtb_pkg;

    localparam int GLINE_W = 16;
    localparam int COLOR_W = 8;
    localparam int PX_W    = 8;
    localparam int PY_W    = 8;
    localparam int ROW_W   = 4;
    localparam int SEGW_W  = 4;
    localparam int RADDR_W = 13;
    localparam int WORD_W  = 32;
    localparam int GH_W    = 5;
    localparam int LINE_W  = 9;
    localparam int ADDR_W  = 16;
    localparam int TDATA_IN_W  = 64;
    localparam int TDATA_OUT_W = 32;

    localparam int OFS_GLINE = 0;
    localparam int OFS_COLOR = OFS_GLINE + GLINE_W;
    localparam int OFS_PX    = OFS_COLOR + COLOR_W;
    localparam int OFS_PY    = OFS_PX + PX_W;
    localparam int OFS_ROW   = OFS_PY + PY_W;
    localparam int OFS_SEGW  = OFS_ROW + ROW_W;
    localparam int OFS_RADDR = OFS_SEGW + SEGW_W;

    localparam logic [GH_W-1:0]    GH_RESET  = 5'd16;
    localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd7;
    localparam logic               REQ_DRAW  = 1'b0;
    localparam logic               REQ_READ  = 1'b1;

    localparam logic [1:0] ASEL_CLR   = 2'd0;
    localparam logic [1:0] ASEL_RADDR = 2'd1;
    localparam logic [1:0] ASEL_A1    = 2'd2;
    localparam logic [1:0] ASEL_A2    = 2'd3;

    typedef struct packed {
        logic       load;
        logic       mem_en;
        logic       mem_we;
        logic [1:0] asel;
        logic       clr_step;
        logic       set_flag;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic skip;
        logic spill;
        logic clr_done;
        logic out_free;
    } t_sts;

    function automatic logic [WORD_W-1:0] expand_row(input logic [GLINE_W-1:0] line,
                                                     input logic [COLOR_W-1:0] color);
        logic [1:0]        hi;
        logic [1:0]        v;
        logic [WORD_W-1:0] word;
        hi   = (color > COLOR_MAX) ? 2'b11 : color[1:0];
        word = '0;
        for (int k = 0; k < 8; k++) begin
            v = line[2*k +: 2];
            if (v != 2'b00) begin
                word[4*k +: 4] = {hi, v};
            end
        end
        return word;
    endfunction

endpackage

### sv/glyph_row_tile_blitter_core.sv
`timescale 1ns / 1ps
// Glyph row tile blitter: ORs expanded 2-bpp glyph rows into a 4-bpp tiled
// canvas held in one single-port RAM of TILES_ACROSS*TILE_ROWS*8 words.
// Input stream: tuser = request kind (0 draw, 1 read), tdata = draw and read
// fields. Output stream: one item per read, tdata = canvas word, tuser =
// canvas-updated flag. Draws give no output item.
// Config channel: writes glyph_height (reset 16), always ready.
// Steps per item, from accept to next ready:
//   read: decode/RAM read, then output register load; the load waits
//   until the output register is free, and the result is valid after it
//   draw, single word: RAM read, then write back; ignored row: decode only
//   draw spilling into the next tile: a second read-modify-write follows
// All cost comes from the single RAM port: each touched word takes a read
// and then a write.
// After reset the RAM is cleared one word per cycle, all TILES_ACROSS*TILE_ROWS*8
// words (8192 by default); input is not accepted until that finishes.
// The output register holds a read result until taken; a read waits for it
// to free up, and draws proceed regardless of a stalled receiver.
module glyph_row_tile_blitter_core #(
    parameter int TILES_ACROSS = 32,
    parameter int TILE_ROWS    = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // glyph_line, color, pixel_x, pixel_y, row_index, seg_width, read_addr
    input  logic [grtb_pkg::TDATA_IN_W-1:0]  i_s_axis_tdata,
    // req_type
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // read_data
    output logic [grtb_pkg::TDATA_OUT_W-1:0] o_m_axis_tdata,
    // canvas_updated
    output logic                             o_m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [grtb_pkg::GH_W-1:0]        i_cfg_data
);
    import grtb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    grtb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    grtb_dpath #(
        .TILES_ACROSS (TILES_ACROSS),
        .TILE_ROWS    (TILE_ROWS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser)
    );

endmodule

### sv/grtb_ctrl.sv
`timescale 1ns / 1ps
module grtb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  grtb_pkg::t_sts i_sts,
    output grtb_pkg::t_cmd o_cmd
);
    import grtb_pkg::*;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_RDONE = 3'd3;
    localparam logic [2:0] S_WR1   = 3'd4;
    localparam logic [2:0] S_RD2   = 3'd5;
    localparam logic [2:0] S_WR2   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.mem_en   = 1'b1;
                o_cmd.mem_we   = 1'b1;
                o_cmd.asel     = ASEL_CLR;
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.is_read) begin
                    o_cmd.mem_en = 1'b1;
                    o_cmd.asel   = ASEL_RADDR;
                    n_state      = S_RDONE;
                end else if (i_sts.skip) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.mem_en = 1'b1;
                    o_cmd.asel   = ASEL_A1;
                    n_state      = S_WR1;
                end
            end
            S_RDONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_WR1: begin
                o_cmd.mem_en   = 1'b1;
                o_cmd.mem_we   = 1'b1;
                o_cmd.asel     = ASEL_A1;
                o_cmd.set_flag = 1'b1;
                n_state        = i_sts.spill ? S_RD2 : S_IDLE;
            end
            S_RD2: begin
                o_cmd.mem_en = 1'b1;
                o_cmd.asel   = ASEL_A2;
                n_state      = S_WR2;
            end
            S_WR2: begin
                o_cmd.mem_en = 1'b1;
                o_cmd.mem_we = 1'b1;
                o_cmd.asel   = ASEL_A2;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/grtb_dpath.sv
`timescale 1ns / 1ps
module grtb_dpath #(
    parameter int TILES_ACROSS = 32,
    parameter int TILE_ROWS    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  grtb_pkg::t_cmd                      i_cmd,
    output grtb_pkg::t_sts                      o_sts,
    input  logic [grtb_pkg::TDATA_IN_W-1:0]     i_s_tdata,
    input  logic                                i_s_tuser,
    input  logic                                i_cfg_valid,
    input  logic [grtb_pkg::GH_W-1:0]           i_cfg_data,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [grtb_pkg::TDATA_OUT_W-1:0]    o_m_tdata,
    output logic                                o_m_tuser
);
    import grtb_pkg::*;

    localparam int CANVAS_WORDS = TILES_ACROSS * TILE_ROWS * 8;
    localparam int LINE_STRIDE  = TILES_ACROSS * 8;
    localparam int AW           = $clog2(CANVAS_WORDS);

    logic [WORD_W-1:0] r_mem [CANVAS_WORDS];
    logic [WORD_W-1:0] r_rdata;

    logic [GH_W-1:0]   r_height;
    logic              r_flag;
    logic [AW-1:0]     r_clr_addr;

    logic              r_is_read;
    logic              r_skip;
    logic              r_spill;
    logic [ADDR_W-1:0] r_addr1;
    logic [RADDR_W-1:0] r_raddr;
    logic [WORD_W-1:0] r_lo;
    logic [WORD_W-1:0] r_hi;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_data;
    logic              r_out_user;

    // item fields
    logic [GLINE_W-1:0] w_gline;
    logic [COLOR_W-1:0] w_color;
    logic [PX_W-1:0]    w_px;
    logic [PY_W-1:0]    w_py;
    logic [ROW_W-1:0]   w_row;
    logic [SEGW_W-1:0]  w_segw;
    logic [LINE_W-1:0]  w_lineno;
    logic [2*WORD_W-1:0] w_shifted;
    logic [4:0]         w_reach;
    logic [ADDR_W-1:0]  w_addr1;

    logic [ADDR_W-1:0]  w_addr;
    logic               w_addr_ok;
    logic [WORD_W-1:0]  w_wdata;

    assign w_gline  = i_s_tdata[OFS_GLINE +: GLINE_W];
    assign w_color  = i_s_tdata[OFS_COLOR +: COLOR_W];
    assign w_px     = i_s_tdata[OFS_PX +: PX_W];
    assign w_py     = i_s_tdata[OFS_PY +: PY_W];
    assign w_row    = i_s_tdata[OFS_ROW +: ROW_W];
    assign w_segw   = i_s_tdata[OFS_SEGW +: SEGW_W];

    assign w_lineno  = LINE_W'(w_py) + LINE_W'(w_row);
    assign w_shifted = {{WORD_W{1'b0}}, expand_row(w_gline, w_color)}
                       << {w_px[2:0], 2'b00};
    assign w_reach   = 5'(w_px[2:0]) + 5'(w_segw);
    assign w_addr1   = ADDR_W'({w_px[PX_W-1:3], 3'b000})
                     + ADDR_W'(w_lineno[LINE_W-1:3]) * ADDR_W'(LINE_STRIDE)
                     + ADDR_W'(w_lineno[2:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_read <= (i_s_tuser == REQ_READ);
            r_skip    <= ({1'b0, w_row} >= r_height);
            r_spill   <= (w_px[2:0] != 3'd0) && (w_reach > 5'd8);
            r_addr1   <= w_addr1;
            r_raddr   <= i_s_tdata[OFS_RADDR +: RADDR_W];
            r_lo      <= w_shifted[WORD_W-1:0];
            r_hi      <= w_shifted[2*WORD_W-1:WORD_W];
        end
    end

    always_comb begin
        case (i_cmd.asel)
            ASEL_CLR:   w_addr = ADDR_W'(r_clr_addr);
            ASEL_RADDR: w_addr = ADDR_W'(r_raddr);
            ASEL_A1:    w_addr = r_addr1;
            ASEL_A2:    w_addr = r_addr1 + ADDR_W'(8);
            default:    w_addr = r_addr1;
        endcase
        case (i_cmd.asel)
            ASEL_CLR: w_wdata = '0;
            ASEL_A2:  w_wdata = r_rdata | r_hi;
            default:  w_wdata = r_rdata | r_lo;
        endcase
    end

    assign w_addr_ok = (w_addr < ADDR_W'(CANVAS_WORDS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_en) begin
            if (i_cmd.mem_we) begin
                if (w_addr_ok) begin
                    r_mem[w_addr[AW-1:0]] <= w_wdata;
                end
            end else begin
                r_rdata <= w_addr_ok ? r_mem[w_addr[AW-1:0]] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height    <= GH_RESET;
            r_flag      <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_height <= i_cfg_data;
            end
            if (i_cmd.set_flag) begin
                r_flag <= 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_rdata;
            r_out_user <= r_flag;
        end
    end

    assign o_sts.is_read  = r_is_read;
    assign o_sts.skip     = r_skip;
    assign o_sts.spill    = r_spill;
    assign o_sts.clr_done = (r_clr_addr == AW'(CANVAS_WORDS - 1));
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule
